@@ hdl/clr_pkg.sv @@
// clr_pkg: event and result types and code constants for the caps lock remapper
// depends on nothing; imported by caps_lock_layout_remapper

package clr_pkg;

	// event kinds
	localparam logic [1:0] REQ_KEY_DOWN = 2'd0;
	localparam logic [1:0] REQ_KEY_UP   = 2'd1;
	localparam logic [1:0] REQ_SYS_DOWN = 2'd2;
	localparam logic [1:0] REQ_SYS_UP   = 2'd3;

	// key classes
	localparam logic [1:0] KEY_OTHER = 2'd0;
	localparam logic [1:0] KEY_CAPS  = 2'd1;
	localparam logic [1:0] KEY_SHIFT = 2'd2;

	// verdicts
	localparam logic [1:0] VERDICT_PASS     = 2'd0;
	localparam logic [1:0] VERDICT_SWALLOW  = 2'd1;
	localparam logic [1:0] VERDICT_CONSUMED = 2'd2;

	// emitted key sequences
	localparam logic [1:0] SEQ_NONE      = 2'd0;
	localparam logic [1:0] SEQ_CAPS_TAP  = 2'd1;
	localparam logic [1:0] SEQ_WIN_SPACE = 2'd2;
	localparam logic [1:0] SEQ_ALT_SHIFT = 2'd3;

	localparam int unsigned IN_TDATA_W  = 16;
	localparam int unsigned OUT_TDATA_W = 8;

	typedef struct packed {
		logic       caps_lamp_on;
		logic       lctrl_held;
		logic       alt_down;
		logic       injected;
		logic       is_action;
		logic [1:0] key_class;
		logic [1:0] req_type;
	} evt_t;

	typedef struct packed {
		logic       enabled_now;
		logic       enable_changed;
		logic       release_lctrl;
		logic       release_alt;
		logic [1:0] emit_sequence;
		logic [1:0] verdict;
	} res_t;

	typedef struct packed {
		logic remap_enabled;
		logic caps_held_seen;
		logic shift_held_seen;
		logic caps_used_toggle;
		logic caps_pass_pending;
	} flags_t;

endpackage

@@ hdl/caps_lock_layout_remapper.sv @@
// caps_lock_layout_remapper: keyboard event filter with enable toggle and layout switch
// depends on clr_pkg (codes, event, result and flag types)
//
// channel | dir | handshake          | payload
// s_      | in  | s_tvalid/s_tready  | s_tdata[15:0] one key event
// m_      | out | m_tvalid/m_tready  | m_tdata[7:0] one verdict
// cfg_    | in  | cfg_valid/cfg_ready| cfg_data popup_mode
//
// one event per cycle sustained while m_tready holds; each event passes two registers
// (input register, then result register); the flag update between them is one level
// reset clears the flags to enabled with nothing held, popup_mode to 0
// an event waits in the input register while the result register is stalled,
// so a new event is still taken once while a result waits
// cfg_ready is always high

module caps_lock_layout_remapper
	import clr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [1:0] req_type, [3:2] key_class, [4] is_action, [5] injected,
	// [6] alt_down, [7] lctrl_held, [8] caps_lamp_on, [15:9] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] verdict, [3:2] emit_sequence, [4] release_alt, [5] release_lctrl,
	// [6] enable_changed, [7] enabled_now
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	logic   evt_valid_s1;
	evt_t   evt_s1;
	logic   res_valid_s2;
	res_t   res_s2;
	flags_t flags_q;
	flags_t flags_nxt;
	res_t   res_nxt;
	logic   popup_mode_q;
	logic   advance;
	logic   alt_held;
	logic   ctl_held;
	logic   is_up;
	logic   done;

	assign advance   = evt_valid_s1 && (!res_valid_s2 || m_tready);
	assign s_tready  = !evt_valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = res_valid_s2;
	assign m_tdata   = res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			popup_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			popup_mode_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			evt_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			evt_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			evt_s1 <= evt_t'(s_tdata[$bits(evt_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
			flags_q      <= '{remap_enabled: 1'b1, default: 1'b0};
		end else begin
			if (advance) begin
				res_valid_s2 <= 1'b1;
				flags_q      <= flags_nxt;
			end else if (m_tready) begin
				res_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign is_up    = (evt_s1.req_type == REQ_KEY_UP) || (evt_s1.req_type == REQ_SYS_UP);
	assign alt_held = (evt_s1.req_type == REQ_SYS_DOWN) && evt_s1.alt_down;
	assign ctl_held = (evt_s1.req_type == REQ_KEY_DOWN) && evt_s1.lctrl_held;

	always_comb begin
		flags_nxt              = flags_q;
		res_nxt                = '0;
		res_nxt.verdict        = VERDICT_PASS;
		res_nxt.emit_sequence  = SEQ_NONE;
		done                   = 1'b0;
		if (evt_s1.is_action && !evt_s1.injected) begin
			case (evt_s1.key_class)
				KEY_CAPS: begin
					if ((alt_held || ctl_held) && !flags_q.caps_held_seen) begin
						// modifier+caps flips the enable state
						flags_nxt.caps_held_seen   = 1'b1;
						flags_nxt.caps_used_toggle = 1'b1;
						flags_nxt.remap_enabled    = !flags_q.remap_enabled;
						res_nxt.enable_changed     = 1'b1;
						res_nxt.release_alt        = alt_held;
						res_nxt.release_lctrl      = ctl_held;
						if (!flags_q.remap_enabled) begin
							flags_nxt.shift_held_seen = 1'b0;
						end
						if (evt_s1.caps_lamp_on) begin
							flags_nxt.caps_pass_pending = 1'b1;
							res_nxt.verdict             = VERDICT_PASS;
						end else begin
							res_nxt.verdict = VERDICT_SWALLOW;
						end
					end else begin
						if (is_up) begin
							flags_nxt.caps_held_seen = 1'b0;
							if (flags_q.caps_pass_pending) begin
								// let the release through so the lamp ends off
								flags_nxt.caps_pass_pending = 1'b0;
								flags_nxt.caps_used_toggle  = 1'b0;
								done                        = 1'b1;
							end else begin
								if (flags_q.caps_used_toggle) begin
									flags_nxt.caps_used_toggle = 1'b0;
								end else if (flags_q.remap_enabled && !flags_q.shift_held_seen) begin
									res_nxt.emit_sequence = popup_mode_q ? SEQ_WIN_SPACE
										: SEQ_ALT_SHIFT;
								end
								flags_nxt.shift_held_seen = 1'b0;
							end
						end
						if (!done) begin
							if (!flags_q.remap_enabled) begin
								res_nxt.verdict = VERDICT_PASS;
							end else begin
								if (((evt_s1.req_type == REQ_KEY_DOWN)
									|| ((evt_s1.req_type == REQ_SYS_DOWN) && !evt_s1.alt_down))
									&& !flags_nxt.caps_held_seen) begin
									flags_nxt.caps_held_seen = 1'b1;
									if (flags_nxt.shift_held_seen) begin
										res_nxt.emit_sequence = SEQ_CAPS_TAP;
									end
								end
								res_nxt.verdict = VERDICT_SWALLOW;
							end
						end
					end
				end
				KEY_SHIFT: begin
					if (is_up && !flags_q.caps_held_seen) begin
						flags_nxt.shift_held_seen = 1'b0;
					end
					if (!flags_q.remap_enabled) begin
						res_nxt.verdict = VERDICT_PASS;
					end else begin
						if ((evt_s1.req_type == REQ_KEY_DOWN) && !flags_nxt.shift_held_seen) begin
							flags_nxt.shift_held_seen = 1'b1;
							if (flags_q.caps_held_seen) begin
								res_nxt.emit_sequence = SEQ_CAPS_TAP;
							end
						end
						res_nxt.verdict = VERDICT_CONSUMED;
					end
				end
				default: begin
					res_nxt.verdict = VERDICT_PASS;
				end
			endcase
		end
		res_nxt.enabled_now = flags_nxt.remap_enabled;
	end

`ifndef ASSERT_OFF
	// an enable-change notice goes with a flip of the stored enable flag
	a_enable_flip: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.enable_changed)
			|=> (flags_q.remap_enabled != $past(flags_q.remap_enabled)))
		else $error("enable change without flag flip");

	// flags move only when an event advances
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(flags_q))
		else $error("flags changed without an event");

	// only one modifier release per event
	a_one_release: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_s2 |-> !(res_s2.release_alt && res_s2.release_lctrl))
		else $error("both modifier releases requested");

	// a passed event never emits a sequence
	a_pass_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_s2 && (res_s2.verdict == VERDICT_PASS))
			|-> (res_s2.emit_sequence == SEQ_NONE))
		else $error("sequence emitted on a passed event");
`endif

endmodule
